[sv/vgd_pkg.sv]
// ----------------------------------------------------------------------------
// vgd_pkg
// Types and constants shared by the voxel grid downsampler files.
// ----------------------------------------------------------------------------
package vgd_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int PROBE_LIMIT_DEF = 8;

    localparam logic [23:0] INV_LEAF_RST  = 24'd65536;
    localparam logic [47:0] RANGE_SQ_RST  = 48'd655360000;
    localparam logic [23:0] BYPASS_ABOVE  = 24'd1310720;
    localparam logic [19:0] HITS_MAX      = 20'hFFFFF;

    localparam logic [26:0] PRIME_X = 27'd73856093;
    localparam logic [26:0] PRIME_Y = 27'd19349663;
    localparam logic [26:0] PRIME_Z = 27'd83492791;

    localparam logic [0:0] CFG_INV_LEAF = 1'd0;
    localparam logic [0:0] CFG_RANGE_SQ = 1'd1;

    typedef enum logic [2:0] {
        KIND_ACCEPT   = 3'd0,
        KIND_FILTER   = 3'd1,
        KIND_DROP     = 3'd2,
        KIND_ECHO     = 3'd3,
        KIND_CENTROID = 3'd4,
        KIND_EMPTY    = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_PRB_RD,
        S_PRB_CK,
        S_SCAN_RD,
        S_SCAN_CK,
        S_DIV_GO,
        S_DIV_W,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               used;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] cz;
        logic signed [43:0] tx;
        logic signed [43:0] ty;
        logic signed [43:0] tz;
        logic        [19:0] hits;
    } t_entry;

endpackage

[sv/vgd_in_if.sv]
// ----------------------------------------------------------------------------
// vgd_in_if
// Input item channel: command and one point.
// ----------------------------------------------------------------------------
interface vgd_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               point_finite;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, point_finite, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, point_finite, output ready);
endinterface

[sv/vgd_out_if.sv]
// ----------------------------------------------------------------------------
// vgd_out_if
// Result item channel.
// ----------------------------------------------------------------------------
interface vgd_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  kind;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic               out_finite;

    modport source (output valid, kind, out_x, out_y, out_z, out_finite, input ready);
    modport sink   (input valid, kind, out_x, out_y, out_z, out_finite, output ready);
endinterface

[sv/vgd_cfg_if.sv]
// ----------------------------------------------------------------------------
// vgd_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface vgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/vgd_mul.sv]
// ----------------------------------------------------------------------------
// vgd_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module vgd_mul (
    input  logic               i_clk,
    input  logic signed [24:0] i_a,
    input  logic signed [27:0] i_b,
    output logic signed [52:0] o_p
);
    logic signed [52:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 53'(i_a * i_b);
    end

    assign o_p = r_p;
endmodule

[sv/vgd_div.sv]
// ----------------------------------------------------------------------------
// vgd_div
// Restoring divider, 64-bit unsigned dividend by 20-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module vgd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [19:0] r_rem;
    logic [19:0] r_dvs;

    logic [20:0] shifted;
    logic [20:0] diff;
    logic        ge;
    logic [19:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[63]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? diff[19:0] : shifted[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

[sv/vgd_mem.sv]
// ----------------------------------------------------------------------------
// vgd_mem
// Voxel table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vgd_mem
    import vgd_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/voxel_grid_downsample.sv]
// ----------------------------------------------------------------------------
// voxel_grid_downsample
// Voxel grid centroid downsampler for Q16.8 points with hashed voxel table.
// ----------------------------------------------------------------------------
// After reset the table is cleared one entry a cycle, during which no item
// is taken. Items are handled one at a time; each gives one result. An added
// point runs nine products through the shared multiplier, takes the home slot
// from the low hash bits and then probes successive slots. A drain scans to
// the next occupied entry, then runs three 64-bit serial divides. Bypass
// echoes skip the multiplier; filtered points finish after the three squares.
module voxel_grid_downsample
    import vgd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vgd_in_if.sink    i_in,
    vgd_out_if.source o_out,
    vgd_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(PROBE_LIMIT) + 1;

    t_state r_state, n_state;

    logic [23:0] r_inv_leaf;
    logic [47:0] r_range_sq;

    logic signed [23:0] r_px, r_py, r_pz;
    logic               r_fin;

    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_pcnt, n_pcnt;
    logic [3:0]    r_step, n_step;
    logic [1:0]    r_axis, n_axis;
    logic [47:0]   r_r2, n_r2;
    logic signed [23:0] r_ix, r_iy, r_iz, n_ix, n_iy, n_iz;
    logic [63:0]   r_hash, n_hash;
    t_entry        r_ent, n_ent;
    logic [AW-1:0] r_drain, n_drain;

    t_kind              r_kind, n_kind;
    logic signed [23:0] r_ox, r_oy, r_oz, n_ox, n_oy, n_oz;
    logic               r_ofin, n_ofin;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic signed [23:0] r_out_x, r_out_y, r_out_z;
    logic               r_out_fin;
    logic               out_load;

    logic signed [24:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [52:0] mul_p;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [19:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quo;

    logic          mem_we;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    logic signed [43:0] div_total;
    logic               div_neg;
    logic [43:0]        div_mag;
    logic [19:0]        div_n;
    logic [23:0]        div_q24;
    logic [AW-1:0]      addr_inc;

    vgd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    vgd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    vgd_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign mem_raddr = r_addr;
    assign addr_inc  = (r_addr == AW'(TABLE_DEPTH - 1)) ? '0 : r_addr + AW'(1);

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_leaf <= INV_LEAF_RST;
            r_range_sq <= RANGE_SQ_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_INV_LEAF: r_inv_leaf <= i_cfg.data[23:0];
                CFG_RANGE_SQ: r_range_sq <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    // multiplier operands
    always_comb begin
        case (r_step)
            4'd0:    begin mul_a = 25'(r_px); mul_b = 28'(r_px); end
            4'd1:    begin mul_a = 25'(r_py); mul_b = 28'(r_py); end
            4'd2:    begin mul_a = 25'(r_pz); mul_b = 28'(r_pz); end
            4'd3:    begin mul_a = 25'(r_px); mul_b = {4'b0, r_inv_leaf}; end
            4'd4:    begin mul_a = 25'(r_py); mul_b = {4'b0, r_inv_leaf}; end
            4'd5:    begin mul_a = 25'(r_pz); mul_b = {4'b0, r_inv_leaf}; end
            4'd6:    begin mul_a = 25'(r_ix); mul_b = {1'b0, PRIME_X}; end
            4'd7:    begin mul_a = 25'(r_iy); mul_b = {1'b0, PRIME_Y}; end
            4'd8:    begin mul_a = 25'(r_iz); mul_b = {1'b0, PRIME_Z}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // divider operands
    always_comb begin
        case (r_axis)
            2'd0:    div_total = r_ent.tx;
            2'd1:    div_total = r_ent.ty;
            default: div_total = r_ent.tz;
        endcase
        div_neg      = div_total[43];
        div_mag      = div_neg ? 44'(-div_total) : 44'(div_total);
        div_n        = (r_ent.hits == '0) ? 20'd1 : r_ent.hits;
        div_q24      = div_neg ? 24'(-div_quo[23:0]) : div_quo[23:0];
        div_dividend = {20'b0, div_mag};
        div_divisor  = div_n;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_pcnt    = r_pcnt;
        n_step    = r_step;
        n_axis    = r_axis;
        n_r2      = r_r2;
        n_ix      = r_ix;
        n_iy      = r_iy;
        n_iz      = r_iz;
        n_hash    = r_hash;
        n_ent     = r_ent;
        n_drain   = r_drain;
        n_kind    = r_kind;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oz      = r_oz;
        n_ofin    = r_ofin;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        out_load  = 1'b0;
        i_in.ready = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_addr    = addr_inc;
                if (r_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                n_ox   = '0;
                n_oy   = '0;
                n_oz   = '0;
                n_ofin = 1'b0;
                n_step = '0;
                n_axis = '0;
                n_r2   = '0;
                n_hash = '0;
                n_cnt  = '0;
                n_pcnt = '0;
                if (i_in.valid) begin
                    if (i_in.cmd) begin
                        n_addr  = r_drain;
                        n_state = S_SCAN_RD;
                    end else if (r_inv_leaf > BYPASS_ABOVE) begin
                        n_kind  = KIND_ECHO;
                        n_ox    = i_in.pos_x;
                        n_oy    = i_in.pos_y;
                        n_oz    = i_in.pos_z;
                        n_ofin  = i_in.point_finite;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL_A;
                    end
                end
            end
            S_MUL_A: begin
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_step  = r_step + 4'd1;
                n_state = S_MUL_A;
                case (r_step)
                    4'd0, 4'd1: n_r2 = r_r2 + mul_p[47:0];
                    4'd2: begin
                        n_r2 = r_r2 + mul_p[47:0];
                        if (!r_fin || n_r2 > r_range_sq) begin
                            n_kind  = KIND_FILTER;
                            n_state = S_DONE;
                        end
                    end
                    4'd3: n_ix = mul_p[47:24];
                    4'd4: n_iy = mul_p[47:24];
                    4'd5: n_iz = mul_p[47:24];
                    4'd6, 4'd7: n_hash = r_hash ^ 64'(mul_p);
                    default: begin
                        n_hash  = r_hash ^ 64'(mul_p);
                        n_addr  = n_hash[AW-1:0];
                        n_state = S_PRB_RD;
                    end
                endcase
            end
            S_PRB_RD: begin
                n_state = S_PRB_CK;
            end
            S_PRB_CK: begin
                if (!mem_rdata.used) begin
                    mem_we         = 1'b1;
                    mem_wdata.used = 1'b1;
                    mem_wdata.cx   = r_ix;
                    mem_wdata.cy   = r_iy;
                    mem_wdata.cz   = r_iz;
                    mem_wdata.tx   = 44'(r_px);
                    mem_wdata.ty   = 44'(r_py);
                    mem_wdata.tz   = 44'(r_pz);
                    mem_wdata.hits = 20'd1;
                    n_kind  = KIND_ACCEPT;
                    n_state = S_DONE;
                end else if (mem_rdata.cx == r_ix && mem_rdata.cy == r_iy
                             && mem_rdata.cz == r_iz) begin
                    if (mem_rdata.hits >= HITS_MAX) begin
                        n_kind = KIND_DROP;
                    end else begin
                        mem_we         = 1'b1;
                        mem_wdata.tx   = mem_rdata.tx + 44'(r_px);
                        mem_wdata.ty   = mem_rdata.ty + 44'(r_py);
                        mem_wdata.tz   = mem_rdata.tz + 44'(r_pz);
                        mem_wdata.hits = mem_rdata.hits + 20'd1;
                        n_kind = KIND_ACCEPT;
                    end
                    n_state = S_DONE;
                end else if (r_pcnt == PW'(PROBE_LIMIT - 1)) begin
                    n_kind  = KIND_DROP;
                    n_state = S_DONE;
                end else begin
                    n_pcnt  = r_pcnt + PW'(1);
                    n_addr  = addr_inc;
                    n_state = S_PRB_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (mem_rdata.used) begin
                    mem_we         = 1'b1;
                    mem_wdata.used = 1'b0;
                    n_ent   = mem_rdata;
                    n_drain = addr_inc;
                    n_kind  = KIND_CENTROID;
                    n_ofin  = 1'b1;
                    n_state = S_DIV_GO;
                end else if (r_cnt == AW'(TABLE_DEPTH - 1)) begin
                    n_drain = '0;
                    n_kind  = KIND_EMPTY;
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt + AW'(1);
                    n_addr  = addr_inc;
                    n_state = S_SCAN_RD;
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_W;
            end
            S_DIV_W: begin
                if (div_done) begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DIV_GO;
                    case (r_axis)
                        2'd0: n_ox = div_q24;
                        2'd1: n_oy = div_q24;
                        default: begin
                            n_oz    = div_q24;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_drain <= n_drain;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_px  <= i_in.pos_x;
            r_py  <= i_in.pos_y;
            r_pz  <= i_in.pos_z;
            r_fin <= i_in.point_finite;
        end
        r_cnt  <= n_cnt;
        r_pcnt <= n_pcnt;
        r_step <= n_step;
        r_axis <= n_axis;
        r_r2   <= n_r2;
        r_ix   <= n_ix;
        r_iy   <= n_iy;
        r_iz   <= n_iz;
        r_hash <= n_hash;
        r_ent  <= n_ent;
        r_kind <= n_kind;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_oz   <= n_oz;
        r_ofin <= n_ofin;
        if (out_load) begin
            r_out_kind <= r_kind;
            r_out_x    <= r_ox;
            r_out_y    <= r_oy;
            r_out_z    <= r_oz;
            r_out_fin  <= r_ofin;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.out_x      = r_out_x;
    assign o_out.out_y      = r_out_y;
    assign o_out.out_z      = r_out_z;
    assign o_out.out_finite = r_out_fin;
endmodule
